// ----- sv/sraw_pkg.sv -----
// Shared types and constants of the sprite attribute RAM window.
package sraw_pkg;

	// Bus access kinds carried in the opcode field.
	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	// Window and control addresses on the bus.
	localparam logic [15:0] ADDR_RECORD0 = 16'h7ff0;
	localparam logic [15:0] ADDR_PACKED  = 16'h7ff4;
	localparam logic [15:0] ADDR_BANK    = 16'h7ff5;
	localparam logic [15:0] ADDR_INDEX   = 16'h7ff6;

	// Bank bases and the offset of the packed attribute bytes.
	localparam logic [15:0] BASE_BANK0  = 16'h1c00;
	localparam logic [15:0] BASE_BANK1  = 16'h1800;
	localparam logic [15:0] PACKED_OFS  = 16'h0200;

	typedef struct packed {
		logic        opcode;
		logic [15:0] bus_address;
		logic [7:0]  write_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] read_byte;
	} out_word_t;

	// What an accepted word asks the sequencer to do.
	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_WPLAIN = 2'd1,
		KIND_WREC   = 2'd2,
		KIND_WPACK  = 2'd3
	} item_kind_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic wr_rec;
		logic wr_pack;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic       clr_last;
		item_kind_t kind;
	} dp_stat_t;

endpackage

// ----- sv/sraw_stream_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
interface sraw_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sprite_attribute_ram_window_top.sv -----
// Sprite attribute RAM window: a byte RAM with an indexed object window on a bus.
// Each word on in_ch is one bus access (opcode, bus_address, write_byte); each
// access returns exactly one word on out_ch whose read_byte is the byte read, or
// zero for a write. Addresses 0x7ff0-0x7ff3 reach the indexed object's record in
// the selected bank, 0x7ff4 its packed attribute byte (a write changes only the
// selected 2-bit field), 0x7ff5 sets the bank and 0x7ff6 the index and shift.
// Every write also lands at the address masked to the RAM size.
// One access is in service at a time: it is accepted, then served in a service
// step, and a new access is accepted only once the block is idle again. The result
// register loads from the service step, or later if the result is parked. A record or
// packed write spends the service step on its window store through the single
// write port of the RAM (the packed byte is read at acceptance, then merged and
// written back in the service step).
// The result register lets the block take the next access while a result waits;
// if the receiver holds off, the sequencer parks the finished result until the
// register frees, and in_ch stays not ready meanwhile. After reset the RAM is
// cleared one byte a cycle, and in_ch stays not ready during that pass.
module sprite_attribute_ram_window_top #(
	parameter int RAM_BYTES = 8192
) (
	input logic        clk,
	input logic        arst_n,
	sraw_stream_if.sink   in_ch,
	sraw_stream_if.source out_ch
);

	sraw_pkg::dp_cmd_t  cmd;
	sraw_pkg::dp_stat_t stat;

	// Control: clearing pass, access steps and the valid bit of the result register.
	sraw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Data: the RAM, the window registers and the result byte.
	sraw_dp #(
		.RAM_BYTES (RAM_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (in_ch.data),
		.stat     (stat),
		.out_word (out_ch.data)
	);

	// No access is taken while the RAM is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !in_ch.ready)
		else $error("access accepted during clearing pass");

	// A pushed result is presented on the next cycle.
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_ch.valid)
		else $error("pushed result not presented");

	// An accepted access keeps in_ch not ready in the cycle after it.
	a_one_in_service: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ch.ready)
		else $error("second access accepted while one is in service");

	// The window store of a write happens once.
	a_single_window_store: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_rec || cmd.wr_pack) |=> !(cmd.wr_rec || cmd.wr_pack))
		else $error("window store repeated");

endmodule

// ----- sv/sraw_ctrl.sv -----
// Sequencer of the sprite attribute RAM window: clearing pass, access steps, result hand-off.
module sraw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sraw_pkg::dp_stat_t stat,
	output sraw_pkg::dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_WREC  = 5'b00100,
		S_WPACK = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   acc;
	logic   finishing;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign acc       = in_ready && in_valid;
	assign finishing = (state_q == S_FIN) || (state_q == S_WREC) || (state_q == S_WPACK);

	assign cmd.clr     = (state_q == S_CLEAR);
	assign cmd.accept  = acc;
	assign cmd.wr_rec  = (state_q == S_WREC);
	assign cmd.wr_pack = (state_q == S_WPACK);
	assign cmd.push    = finishing && out_free;

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (acc) begin
					unique case (stat.kind)
						sraw_pkg::KIND_WREC:  state_d = S_WREC;
						sraw_pkg::KIND_WPACK: state_d = S_WPACK;
						default:              state_d = S_FIN;
					endcase
				end
			end
			S_WREC, S_WPACK: begin
				state_d = out_free ? S_IDLE : S_FIN;
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/sraw_dp.sv -----
// Datapath of the sprite attribute RAM window: RAM, window registers and address logic.
module sraw_dp #(
	parameter int RAM_BYTES = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sraw_pkg::dp_cmd_t   cmd,
	input  sraw_pkg::in_word_t  in_word,
	output sraw_pkg::dp_stat_t  stat,
	output sraw_pkg::out_word_t out_word
);

	localparam int AW = $clog2(RAM_BYTES);

	logic [7:0]    mem [RAM_BYTES];
	logic [7:0]    rdata_q;
	logic          bank_q;
	logic [6:0]    index_q;
	logic [1:0]    shift_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] rec_addr_q;
	logic [7:0]    wdata_q;
	logic          is_read_q;
	logic [7:0]    out_q;

	logic [AW-1:0] base;
	logic [AW-1:0] rec_addr;
	logic [AW-1:0] pk_addr;
	logic [AW-1:0] plain;
	logic          hit_rec;
	logic          hit_pack;
	logic          is_write;
	logic [2:0]    shamt;
	logic [7:0]    merged;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [AW-1:0] raddr;

	assign base     = bank_q ? AW'(sraw_pkg::BASE_BANK1) : AW'(sraw_pkg::BASE_BANK0);
	assign rec_addr = base + AW'({index_q, 2'b00}) + AW'(in_word.bus_address[1:0]);
	assign pk_addr  = base + AW'(index_q[6:2]) + AW'(sraw_pkg::PACKED_OFS);
	assign plain    = in_word.bus_address[AW-1:0];
	assign hit_rec  = (in_word.bus_address[15:2] == sraw_pkg::ADDR_RECORD0[15:2]);
	assign hit_pack = (in_word.bus_address == sraw_pkg::ADDR_PACKED);
	assign is_write = (in_word.opcode == sraw_pkg::OP_WRITE);

	always_comb begin
		stat.clr_last = &clr_q;
		priority if (!is_write)  stat.kind = sraw_pkg::KIND_READ;
		else if (hit_rec)        stat.kind = sraw_pkg::KIND_WREC;
		else if (hit_pack)       stat.kind = sraw_pkg::KIND_WPACK;
		else                     stat.kind = sraw_pkg::KIND_WPLAIN;
	end

	// The field shift stays put while a packed write is in flight.
	assign shamt  = {shift_q, 1'b0};
	assign merged = (rdata_q & ~(8'd3 << shamt)) | ({6'd0, wdata_q[1:0]} << shamt);

	always_comb begin
		we    = 1'b0;
		waddr = plain;
		wdata = in_word.write_byte;
		priority if (cmd.clr) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 8'd0;
		end else if (cmd.accept && is_write) begin
			we = 1'b1;
		end else if (cmd.wr_rec) begin
			we    = 1'b1;
			waddr = rec_addr_q;
			wdata = wdata_q;
		end else if (cmd.wr_pack) begin
			we    = 1'b1;
			waddr = pk_addr;
			wdata = merged;
		end else begin
			we = 1'b0;
		end
	end

	always_comb begin
		priority if (hit_rec) raddr = rec_addr;
		else if (hit_pack)    raddr = pk_addr;
		else                  raddr = plain;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.accept) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rec_addr_q <= rec_addr;
			wdata_q    <= in_word.write_byte;
			is_read_q  <= !is_write;
		end
		if (cmd.push) out_q <= is_read_q ? rdata_q : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			index_q <= 7'd0;
			shift_q <= 2'd0;
			clr_q   <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + AW'(1);
			if (cmd.accept && is_write) begin
				if (in_word.bus_address == sraw_pkg::ADDR_BANK) begin
					bank_q <= in_word.write_byte[0];
				end
				if (in_word.bus_address == sraw_pkg::ADDR_INDEX) begin
					index_q <= in_word.write_byte[6:0];
					shift_q <= in_word.write_byte[1:0];
				end
			end
		end
	end

	assign out_word.read_byte = out_q;

endmodule
